FILE: rtl/lnp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lnp_pkg : shared types and constants for the next-permutation core
// Transfer payloads, opcodes and the controller/datapath interface structs.
// ============================================================================
package lnp_pkg;

    localparam int ELEM_BITS   = 4;
    localparam int MAX_LEN_DEF = 16;
    localparam int SEQ_W       = 64;
    localparam int LEN_W       = 5;
    localparam int OP_W        = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [SEQ_W-1:0] load_value;
    } t_in;

    typedef struct packed {
        logic [SEQ_W-1:0] sequence_res;
        logic             advanced;
    } t_out;

    typedef struct packed {
        logic apply;
        logic find;
        logic succ;
        logic swap;
        logic rev;
        logic out_load;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic succ_right;
    } t_stat;

endpackage

FILE: rtl/lexicographic_next_permutation_core.sv
`timescale 1ns / 1ps
// ============================================================================
// lexicographic_next_permutation_core : next-permutation engine
// Steps a stored sequence of four-bit elements to its lexicographic successor.
// ============================================================================
// Each transfer returns the packed sequence after the operation. Restart, load
// and unused opcodes pass from accept to result and the output register; an
// advance steps through accept, pivot search, successor search, swap, suffix
// reversal and result, skipping swap and reversal when the sequence has no
// ascent. One item is in flight at a time, set by the sequencer's walk through
// those phases; a finished result may wait on the output while the next item
// is taken. The user must see that length_in_use is written through i_cfg_wr_en
// only while idle; the block does not enforce it. Values above MAX_LEN act as MAX_LEN.
module lexicographic_next_permutation_core #(
    parameter int MAX_LEN = lnp_pkg::MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  lnp_pkg::t_in               i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output lnp_pkg::t_out              o_data,
    input  logic                       i_cfg_wr_en,
    input  logic [lnp_pkg::LEN_W-1:0]  i_cfg_wr_data
);

    lnp_pkg::t_cmd  w_cmd;
    lnp_pkg::t_stat w_stat;

    lnp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_data.opcode),
        .i_stall  (i_stall),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    lnp_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data        (i_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_data        (o_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while previous item in flight");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid)
        else $error("result loaded but not presented");

    a_succ_right_of_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.swap |-> w_stat.succ_right)
        else $error("successor not right of pivot");

    a_adv_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && w_cmd.adv) |-> w_stat.found)
        else $error("advanced flagged without an ascent");

endmodule

FILE: rtl/lnp_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// lnp_ctrl : sequencer for the next-permutation core
// Steps an advance through pivot search and, on an ascent, successor search,
// swap and suffix reversal, and owns the input and output handshakes.
// ============================================================================
module lnp_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lnp_pkg::OP_W-1:0]  i_opcode,
    input  logic                      i_stall,
    input  lnp_pkg::t_stat            i_stat,
    output lnp_pkg::t_cmd             o_cmd,
    output logic                      o_stall,
    output logic                      o_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SUCC = 3'd2;
    localparam logic [2:0] S_SWAP = 3'd3;
    localparam logic [2:0] S_REV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_adv, n_adv;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_adv       = r_adv;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.adv   = r_adv;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_adv = 1'b0;
                    if (i_opcode == lnp_pkg::OP_ADVANCE) begin
                        n_state = S_FIND;
                    end else begin
                        o_cmd.apply = 1'b1;
                        n_state     = S_DONE;
                    end
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = S_SUCC;
            end
            S_SUCC: begin
                if (i_stat.found) begin
                    o_cmd.succ = 1'b1;
                    n_state    = S_SWAP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_REV;
            end
            S_REV: begin
                o_cmd.rev = 1'b1;
                n_adv     = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_adv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_adv       <= n_adv;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/lnp_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// lnp_datapath : element store and permutation datapath
// Holds the sequence and length register, the pivot and successor indices,
// and the output register.
// ============================================================================
module lnp_datapath #(
    parameter int MAX_LEN = lnp_pkg::MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lnp_pkg::t_in               i_data,
    input  logic                       i_cfg_wr_en,
    input  logic [lnp_pkg::LEN_W-1:0]  i_cfg_wr_data,
    input  lnp_pkg::t_cmd              i_cmd,
    output lnp_pkg::t_stat             o_stat,
    output lnp_pkg::t_out              o_data
);

    localparam int EB = lnp_pkg::ELEM_BITS;
    localparam int IW = $clog2(MAX_LEN);
    localparam int MW = $clog2(MAX_LEN + 1);

    logic [MAX_LEN-1:0][EB-1:0] r_seq, n_seq;
    logic [lnp_pkg::LEN_W-1:0]  r_len;
    logic [IW-1:0]              r_piv, r_succ;
    logic                       r_found;
    lnp_pkg::t_out              r_out;

    logic [MW-1:0]   w_len;
    logic [IW-1:0]   w_piv, w_succ;
    logic            w_found;
    logic [EB-1:0]   w_pv, w_sv;
    logic [IW:0]     w_sum;

    assign w_len = (r_len > lnp_pkg::LEN_W'(MAX_LEN)) ? MW'(MAX_LEN) : MW'(r_len);
    assign w_pv  = r_seq[r_piv];
    assign w_sv  = r_seq[r_succ];
    assign w_sum = (IW+1)'(w_len) + (IW+1)'(r_piv);

    // rightmost ascent
    always_comb begin
        w_piv   = '0;
        w_found = 1'b0;
        for (int k = 0; k < MAX_LEN - 1; k++) begin
            if ((MW'(k + 1) < w_len) && (r_seq[k] < r_seq[k + 1])) begin
                w_piv   = IW'(k);
                w_found = 1'b1;
            end
        end
    end

    // rightmost element larger than the pivot
    always_comb begin
        w_succ = '0;
        for (int k = 0; k < MAX_LEN; k++) begin
            if ((IW'(k) > r_piv) && (MW'(k) < w_len) && (r_seq[k] > w_pv)) begin
                w_succ = IW'(k);
            end
        end
    end

    always_comb begin
        n_seq = r_seq;
        if (i_cmd.apply) begin
            if (i_data.opcode == lnp_pkg::OP_RESTART) begin
                for (int k = 0; k < MAX_LEN; k++) begin
                    n_seq[k] = EB'(k);
                end
            end else if (i_data.opcode == lnp_pkg::OP_LOAD) begin
                for (int k = 0; k < MAX_LEN; k++) begin
                    n_seq[k] = i_data.load_value[k*EB +: EB];
                end
            end
        end else if (i_cmd.swap) begin
            for (int k = 0; k < MAX_LEN; k++) begin
                if (IW'(k) == r_piv) begin
                    n_seq[k] = w_sv;
                end else if (IW'(k) == r_succ) begin
                    n_seq[k] = w_pv;
                end
            end
        end else if (i_cmd.rev) begin
            // suffix lane k takes element (pivot + length - k)
            for (int k = 0; k < MAX_LEN; k++) begin
                if ((IW'(k) > r_piv) && (MW'(k) < w_len)) begin
                    n_seq[k] = r_seq[IW'(w_sum - (IW+1)'(k))];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_LEN; k++) begin
                r_seq[k] <= EB'(k);
            end
            r_len   <= lnp_pkg::LEN_RESET;
            r_found <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (i_cmd.find) begin
                r_found <= w_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_piv <= w_piv;
        end
        if (i_cmd.succ) begin
            r_succ <= w_succ;
        end
        if (i_cmd.out_load) begin
            r_out.sequence_res <= lnp_pkg::SEQ_W'(r_seq);
            r_out.advanced     <= i_cmd.adv;
        end
    end

    assign o_stat.found      = r_found;
    assign o_stat.succ_right = (r_succ > r_piv);
    assign o_data            = r_out;

endmodule
